### rtl/lcabl_pkg.sv
// ----------------------------------------------------------------------------
// lcabl_pkg
// Shared types and constants of the binary-lifting lowest common ancestor engine.
// ----------------------------------------------------------------------------
package lcabl_pkg;

   localparam int CmdW   = 2;
   localparam int NodeW  = 10;
   localparam int ParW   = 11;
   localparam int DepthW = 10;
   localparam int CountW = 11;

   localparam int ReqDataW = 48;
   localparam int RspDataW = 16;

   typedef enum logic [CmdW-1:0] {
      CMD_LOAD  = 2'd0,
      CMD_BUILD = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD,
      S_B_RD,
      S_B_MID,
      S_B_WR,
      S_B_NEXT,
      S_Q_DA,
      S_Q_DB,
      S_Q_SWAP,
      S_L_CHK,
      S_L_UP,
      S_L_DEP,
      S_Q_EQ,
      S_J_RDP,
      S_J_RDQ,
      S_J_CHK,
      S_F_RD,
      S_F_RES,
      S_OUT
   } ctl_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACCEPT,
      OP_LOAD,
      OP_B_RD,
      OP_B_MID,
      OP_B_WR,
      OP_B_NEXT,
      OP_Q_DA,
      OP_Q_DB,
      OP_Q_SWAP,
      OP_L_CHK,
      OP_L_UP,
      OP_L_DEP,
      OP_Q_EQ,
      OP_J_RDP,
      OP_J_RDQ,
      OP_J_CHK,
      OP_F_RD,
      OP_F_RES,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_ctrl_type;

   typedef struct packed {
      cmd_type req_cmd;
      logic    in_bad;
      logic    cnt_zero;
      logic    node_last;
      logic    lvl_zero;
      logic    lvl_last;
      logic    lift_cond;
      logic    ent_valid;
      logic    pair_lift;
      logic    p_eq_q;
      logic    out_free;
   } dp_status_type;

endpackage

### rtl/lcabl_ctrl.sv
// ----------------------------------------------------------------------------
// lcabl_ctrl
// Sequencer for load, table build and query walks over the datapath.
// ----------------------------------------------------------------------------
module lcabl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  lcabl_pkg::dp_status_type status,
   output lcabl_pkg::dp_ctrl_type   ctrl
);
   import lcabl_pkg::*;

   ctl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (status.req_cmd)
                  CMD_LOAD:  state_in = S_LOAD;
                  CMD_BUILD: state_in = status.cnt_zero ? S_IDLE : S_B_RD;
                  CMD_QUERY: state_in = status.in_bad ? S_OUT : S_Q_DA;
                  CMD_NOP:   state_in = S_IDLE;
               endcase
            end
         end
         S_LOAD:   state_in = S_IDLE;
         S_B_RD:   state_in = S_B_MID;
         S_B_MID:  state_in = (status.lvl_zero || !status.ent_valid) ? S_B_NEXT : S_B_WR;
         S_B_WR:   state_in = S_B_NEXT;
         S_B_NEXT: state_in = (status.node_last && status.lvl_last) ? S_IDLE : S_B_RD;
         S_Q_DA:   state_in = S_Q_DB;
         S_Q_DB:   state_in = S_Q_SWAP;
         S_Q_SWAP: state_in = S_L_CHK;
         S_L_CHK: begin
            priority if (status.lift_cond) state_in = S_L_UP;
            else if (status.lvl_zero)      state_in = S_Q_EQ;
            else                           state_in = S_L_CHK;
         end
         S_L_UP: begin
            priority if (status.ent_valid) state_in = S_L_DEP;
            else if (status.lvl_zero)      state_in = S_Q_EQ;
            else                           state_in = S_L_CHK;
         end
         S_L_DEP:  state_in = status.lvl_zero ? S_Q_EQ : S_L_CHK;
         S_Q_EQ:   state_in = status.p_eq_q ? S_OUT : S_J_RDP;
         S_J_RDP:  state_in = S_J_RDQ;
         S_J_RDQ:  state_in = S_J_CHK;
         S_J_CHK:  state_in = status.lvl_zero ? S_F_RD : S_J_RDP;
         S_F_RD:   state_in = S_F_RES;
         S_F_RES:  state_in = S_OUT;
         S_OUT:    state_in = status.out_free ? S_IDLE : S_OUT;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      ctrl.op    = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctrl.op = OP_ACCEPT;
            end
         end
         S_LOAD:   ctrl.op = OP_LOAD;
         S_B_RD:   ctrl.op = OP_B_RD;
         S_B_MID:  ctrl.op = OP_B_MID;
         S_B_WR:   ctrl.op = OP_B_WR;
         S_B_NEXT: ctrl.op = OP_B_NEXT;
         S_Q_DA:   ctrl.op = OP_Q_DA;
         S_Q_DB:   ctrl.op = OP_Q_DB;
         S_Q_SWAP: ctrl.op = OP_Q_SWAP;
         S_L_CHK:  ctrl.op = OP_L_CHK;
         S_L_UP:   ctrl.op = OP_L_UP;
         S_L_DEP:  ctrl.op = OP_L_DEP;
         S_Q_EQ:   ctrl.op = OP_Q_EQ;
         S_J_RDP:  ctrl.op = OP_J_RDP;
         S_J_RDQ:  ctrl.op = OP_J_RDQ;
         S_J_CHK:  ctrl.op = OP_J_CHK;
         S_F_RD:   ctrl.op = OP_F_RD;
         S_F_RES:  ctrl.op = OP_F_RES;
         S_OUT: begin
            if (status.out_free) begin
               ctrl.op = OP_OUT;
            end
         end
         default:  ctrl.op = OP_NONE;
      endcase
   end

endmodule

### rtl/lcabl_datapath.sv
// ----------------------------------------------------------------------------
// lcabl_datapath
// Jump table and depth memories, walk registers and the result register.
// ----------------------------------------------------------------------------
module lcabl_datapath #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [lcabl_pkg::CountW-1:0]    csr_wr_data,
   input  logic [lcabl_pkg::CmdW-1:0]      in_cmd,
   input  logic [lcabl_pkg::NodeW-1:0]     in_node_a,
   input  logic [lcabl_pkg::ParW-1:0]      in_parent_node,
   input  logic [lcabl_pkg::DepthW-1:0]    in_node_depth,
   input  logic [lcabl_pkg::NodeW-1:0]     in_node_b,
   input  lcabl_pkg::dp_ctrl_type          ctrl,
   output lcabl_pkg::dp_status_type        status,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [lcabl_pkg::NodeW-1:0]     rsp_ancestor,
   output logic                            rsp_bad_node
);
   import lcabl_pkg::*;

   localparam int IdxW  = $clog2(MAX_NODES);
   localparam int EntW  = IdxW + 1;
   localparam int CntW  = $clog2(MAX_NODES + 1);
   localparam int LvlW  = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
   localparam logic [LvlW-1:0] TopLvl = LvlW'(LIFT_LEVELS - 1);
   localparam logic [EntW-1:0] NoneEnt = {1'b1, {IdxW{1'b0}}};

   logic [EntW-1:0]   jt_mem [LIFT_LEVELS][MAX_NODES];
   logic [DepthW-1:0] dep_mem [MAX_NODES];

   logic [CountW-1:0] node_count_ff, node_count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [NodeW-1:0]  rsp_anc_ff;
   logic              rsp_bad_ff;

   logic [IdxW-1:0]   a_ff, b_ff, p_ff, q_ff, up_idx_ff;
   logic              up_ok_ff, load_ok_ff;
   logic [EntW-1:0]   par_ff;
   logic [DepthW-1:0] dep_ff, da_ff, dp_ff, dq_ff;
   logic [CntW-1:0]   i_ff;
   logic [LvlW-1:0]   j_ff;
   logic [NodeW-1:0]  res_anc_ff;
   logic              res_bad_ff;

   logic [EntW-1:0]   jt_rd_ff;
   logic [DepthW-1:0] dep_rd_ff;

   logic              jt_re, jt_we, dep_re, dep_we;
   logic [LvlW-1:0]   jt_rd_lvl, jt_wr_lvl;
   logic [IdxW-1:0]   jt_rd_idx, jt_wr_idx, dep_rd_idx, dep_wr_idx;
   logic [EntW-1:0]   jt_wr_data;
   logic [DepthW-1:0] dep_wr_data;

   logic [CntW-1:0]   cnt;
   logic              ent_ok;
   logic [IdxW-1:0]   ent_idx;
   logic [EntW-1:0]   ent_norm;
   logic              lvl_zero;
   logic [LvlW-1:0]   j_dec;

   assign cnt      = (32'(node_count_ff) > 32'(MAX_NODES)) ? CntW'(MAX_NODES)
                                                           : CntW'(node_count_ff);
   assign ent_idx  = jt_rd_ff[IdxW-1:0];
   assign ent_ok   = !jt_rd_ff[IdxW] && (32'(ent_idx) < 32'(cnt));
   assign ent_norm = ent_ok ? {1'b0, ent_idx} : NoneEnt;
   assign lvl_zero = (j_ff == '0);
   assign j_dec    = lvl_zero ? j_ff : j_ff - LvlW'(1);

   always_comb begin
      status.req_cmd   = cmd_type'(in_cmd);
      status.in_bad    = (32'(in_node_a) >= 32'(cnt)) || (32'(in_node_b) >= 32'(cnt));
      status.cnt_zero  = (cnt == '0);
      status.node_last = (32'(i_ff) + 32'd1 >= 32'(cnt));
      status.lvl_zero  = lvl_zero;
      status.lvl_last  = (j_ff == TopLvl);
      status.lift_cond = (32'(dp_ff) >= 32'(dq_ff) + (32'd1 << j_ff));
      status.ent_valid = ent_ok;
      status.pair_lift = up_ok_ff && ent_ok && (up_idx_ff != ent_idx);
      status.p_eq_q    = (p_ff == q_ff);
      status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   // memory port control
   always_comb begin
      jt_re       = 1'b0;
      jt_rd_lvl   = j_ff;
      jt_rd_idx   = p_ff;
      jt_we       = 1'b0;
      jt_wr_lvl   = j_ff;
      jt_wr_idx   = IdxW'(i_ff);
      jt_wr_data  = ent_norm;
      dep_re      = 1'b0;
      dep_rd_idx  = a_ff;
      dep_we      = 1'b0;
      dep_wr_idx  = a_ff;
      dep_wr_data = dep_ff;
      unique case (ctrl.op)
         OP_LOAD: begin
            jt_we      = load_ok_ff;
            jt_wr_lvl  = '0;
            jt_wr_idx  = a_ff;
            jt_wr_data = par_ff;
            dep_we     = load_ok_ff;
         end
         OP_B_RD: begin
            jt_re     = 1'b1;
            jt_rd_lvl = lvl_zero ? j_ff : j_ff - LvlW'(1);
            jt_rd_idx = IdxW'(i_ff);
         end
         OP_B_MID: begin
            if (lvl_zero || !ent_ok) begin
               jt_we = 1'b1;
            end else begin
               jt_re     = 1'b1;
               jt_rd_lvl = j_ff - LvlW'(1);
               jt_rd_idx = ent_idx;
            end
         end
         OP_B_WR:  jt_we = 1'b1;
         OP_Q_DA:  dep_re = 1'b1;
         OP_Q_DB: begin
            dep_re     = 1'b1;
            dep_rd_idx = b_ff;
         end
         OP_L_CHK: jt_re = status.lift_cond;
         OP_L_UP: begin
            dep_re     = ent_ok;
            dep_rd_idx = ent_idx;
         end
         OP_J_RDP: jt_re = 1'b1;
         OP_J_RDQ: begin
            jt_re     = 1'b1;
            jt_rd_idx = q_ff;
         end
         OP_F_RD: begin
            jt_re     = 1'b1;
            jt_rd_lvl = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (jt_we) begin
         jt_mem[jt_wr_lvl][jt_wr_idx] <= jt_wr_data;
      end
      if (jt_re) begin
         jt_rd_ff <= jt_mem[jt_rd_lvl][jt_rd_idx];
      end
      if (dep_we) begin
         dep_mem[dep_wr_idx] <= dep_wr_data;
      end
      if (dep_re) begin
         dep_rd_ff <= dep_mem[dep_rd_idx];
      end
   end

   always_comb begin
      node_count_in = csr_wr_en ? csr_wr_data : node_count_ff;
      rsp_valid_in  = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (ctrl.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= CountW'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // walk registers
   always_ff @(posedge clock) begin
      unique case (ctrl.op)
         OP_ACCEPT: begin
            a_ff       <= IdxW'(in_node_a);
            b_ff       <= IdxW'(in_node_b);
            load_ok_ff <= (32'(in_node_a) < 32'(MAX_NODES));
            par_ff     <= (in_parent_node[ParW-1] ||
                           32'(in_parent_node[ParW-2:0]) >= 32'(MAX_NODES))
                          ? NoneEnt : {1'b0, IdxW'(in_parent_node[ParW-2:0])};
            dep_ff     <= in_node_depth;
            i_ff       <= '0;
            j_ff       <= '0;
            res_anc_ff <= '0;
            res_bad_ff <= status.in_bad;
         end
         OP_B_NEXT: begin
            if (status.node_last) begin
               i_ff <= '0;
               j_ff <= j_ff + LvlW'(1);
            end else begin
               i_ff <= i_ff + CntW'(1);
            end
         end
         OP_Q_DB:  da_ff <= dep_rd_ff;
         OP_Q_SWAP: begin
            j_ff <= TopLvl;
            if (da_ff < dep_rd_ff) begin
               p_ff  <= b_ff;
               q_ff  <= a_ff;
               dp_ff <= dep_rd_ff;
               dq_ff <= da_ff;
            end else begin
               p_ff  <= a_ff;
               q_ff  <= b_ff;
               dp_ff <= da_ff;
               dq_ff <= dep_rd_ff;
            end
         end
         OP_L_CHK: begin
            if (!status.lift_cond) begin
               j_ff <= j_dec;
            end
         end
         OP_L_UP: begin
            if (ent_ok) begin
               p_ff <= ent_idx;
            end else begin
               j_ff <= j_dec;
            end
         end
         OP_L_DEP: begin
            dp_ff <= dep_rd_ff;
            j_ff  <= j_dec;
         end
         OP_Q_EQ: begin
            if (status.p_eq_q) begin
               res_anc_ff <= NodeW'(p_ff);
            end else begin
               j_ff <= TopLvl;
            end
         end
         OP_J_RDQ: begin
            up_ok_ff  <= ent_ok;
            up_idx_ff <= ent_idx;
         end
         OP_J_CHK: begin
            if (status.pair_lift) begin
               p_ff <= up_idx_ff;
               q_ff <= ent_idx;
            end
            j_ff <= j_dec;
         end
         OP_F_RES:  res_anc_ff <= ent_ok ? NodeW'(ent_idx) : '0;
         OP_OUT: begin
            rsp_anc_ff <= res_anc_ff;
            rsp_bad_ff <= res_bad_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_ancestor = rsp_anc_ff;
   assign rsp_bad_node = rsp_bad_ff;

endmodule

### rtl/lca_binary_lifting_top.sv
// ----------------------------------------------------------------------------
// lca_binary_lifting_top
// Binary-lifting lowest common ancestor engine.
//
// Items arrive on the req channel: tuser selects load, build, query or nop.
// A load writes one node's parent and depth and gives no item.
// A build fills the jump table one node of one level at a time, by read,
// mid, optional write and next steps; it gives no item.
// A query gives one rsp item after a depth lift and, unless the nodes have
// met, a joint lift; the walk is bound by the single jump table read port
// with its registered read. A bad index skips the walk and answers with
// bad_node set.
// One item is worked on at a time. The rsp register holds a finished item
// while the next req item is taken; a query finishing while rsp is still
// stalled waits until the receiver takes the earlier item.
// Reset clears the sequencer and the rsp valid flag and sets node_count to 1;
// table and depth memories hold nothing defined until loaded and built.
// csr writes node_count; the user must write it only while idle (unchecked).
// ----------------------------------------------------------------------------
module lca_binary_lifting_top #(
   parameter int MAX_NODES   = 1024,
   parameter int LIFT_LEVELS = 10
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [lcabl_pkg::CountW-1:0]     csr_wr_data,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // node_a[9:0], parent_node[20:10], node_depth[30:21], node_b[40:31], zero fill
   input  logic [lcabl_pkg::ReqDataW-1:0]   req_tdata,
   // cmd[1:0]
   input  logic [lcabl_pkg::CmdW-1:0]       req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // ancestor[9:0], zero fill
   output logic [lcabl_pkg::RspDataW-1:0]   rsp_tdata,
   // bad_node[0]
   output logic [0:0]                       rsp_tuser
);
   import lcabl_pkg::*;

   dp_ctrl_type      ctrl;
   dp_status_type    status;
   logic [NodeW-1:0] rsp_ancestor;
   logic             rsp_bad_node;

   lcabl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   lcabl_datapath #(
      .MAX_NODES   (MAX_NODES),
      .LIFT_LEVELS (LIFT_LEVELS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .in_cmd         (req_tuser),
      .in_node_a      (req_tdata[9:0]),
      .in_parent_node (req_tdata[20:10]),
      .in_node_depth  (req_tdata[30:21]),
      .in_node_b      (req_tdata[40:31]),
      .ctrl           (ctrl),
      .status         (status),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_ancestor   (rsp_ancestor),
      .rsp_bad_node   (rsp_bad_node)
   );

   assign rsp_tdata = {{(RspDataW - NodeW){1'b0}}, rsp_ancestor};
   assign rsp_tuser = rsp_bad_node;

endmodule
